>>> rtl/core/geq_pkg.sv
// Shared types and constants for the gamepad event qualifier.
// Used by the controller, the datapath and the top level.
`default_nettype none
package geq_pkg;

  // Event kinds carried on the output tuser.
  localparam logic [2:0] KIND_DPAD   = 3'd0;
  localparam logic [2:0] KIND_WALK   = 3'd1;
  localparam logic [2:0] KIND_CURSOR = 3'd2;
  localparam logic [2:0] KIND_MOUSE  = 3'd3;
  localparam logic [2:0] KIND_ACTION = 3'd4;
  localparam logic [2:0] KIND_TARGET = 3'd5;
  localparam logic [2:0] KIND_CAPT   = 3'd6;
  localparam logic [2:0] KIND_SELECT = 3'd7;

  // Directions.
  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_RIGHT = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_DEADZONE = 3'd0;
  localparam logic [2:0] REG_REPEAT   = 3'd1;
  localparam logic [2:0] REG_SPEED    = 3'd2;
  localparam logic [2:0] REG_TRIGGER  = 3'd3;
  localparam logic [2:0] REG_WIDTH    = 3'd4;
  localparam logic [2:0] REG_HEIGHT   = 3'd5;

  localparam logic [14:0] FULL_SCALE = 15'd32767;
  localparam int NumSlots = 15;
  localparam int DivBits  = 24;
  localparam int CntW     = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input word
    logic mul;     // register both speed products
    logic dload;   // start a division
    logic dstep;   // one restoring division step
    logic dsave;   // store the signed quotient
    logic dsel;    // 0 horizontal axis, 1 vertical axis
    logic upd;     // update state and build the event list
    logic emit;    // move the next event into the output register
  } geq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pend_any;
    logic out_free;
  } geq_stat_t;

endpackage
`default_nettype wire

>>> rtl/core/gamepad_event_qualifier_unit.sv
// Top level of the gamepad event qualifier.
// Depends on geq_pkg, geq_ctrl and geq_dp.
//
// One poll sample is taken on the slave stream (s_tvalid/s_tready, 152-bit
// s_tdata) and turns into zero to fifteen events on the master stream,
// the last one of a sample marked by m_tlast, the kind carried on m_tuser.
// Registers are written on the cfg channel (cfg_valid/cfg_ready, index and
// 16-bit data); cfg_ready is high whenever reset is low and a write applies
// next cycle.
// Each sample, once accepted, takes a product step, two divisions for the
// cursor speeds on one shared restoring divider (a load, 24 steps of one
// quotient bit and a save each), and an update; then one event word per
// cycle while the receiver keeps up.
// The next sample is taken once the last event word of the previous one
// has entered the output register and the controller is idle again, even
// while the receiver has not yet taken that word.
// A stalled receiver holds the output word and pauses the event sequence.
// Synchronous reset restores the register defaults, clears the stick hold,
// timers, cursor and button history, and empties the output register.
`default_nettype none
module gamepad_event_qualifier_unit (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // left_x, left_y, right_x, right_y, left_trigger, right_trigger,
  // button_mask, host_pointer_x, host_pointer_y, elapsed_ms, zero pad
  input  wire logic [151:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // event_code, event_flag, cursor_x, cursor_y, zero pad
  output logic [31:0]       m_tdata,
  // event_kind
  output logic [2:0]        m_tuser,
  output logic              m_tlast
);
  import geq_pkg::*;

  geq_cmd_t  cmd;
  geq_stat_t stat;

  assign cfg_ready = !rst;

  geq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  geq_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
`default_nettype wire

>>> rtl/core/geq_ctrl.sv
// Controller state machine of the gamepad event qualifier.
// Depends on geq_pkg; drives the datapath by command and status.
`default_nettype none
module geq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  input  wire geq_pkg::geq_stat_t stat,
  output geq_pkg::geq_cmd_t      cmd
);
  import geq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_LOAD, S_STEP, S_SAVE, S_UPD, S_EMIT
  } state_t;

  state_t          state;
  logic            sel;
  logic [CntW-1:0] cnt;

  // Command decode from the current state.
  always_comb begin
    cmd       = '0;
    cmd.dsel  = sel;
    s_tready  = (state == S_IDLE) && !rst;
    cmd.load  = s_tready && s_tvalid;
    cmd.mul   = (state == S_MUL);
    cmd.dload = (state == S_LOAD);
    cmd.dstep = (state == S_STEP);
    cmd.dsave = (state == S_SAVE);
    cmd.upd   = (state == S_UPD);
    cmd.emit  = (state == S_EMIT) && stat.pend_any && stat.out_free;
  end

  // Sequencing: the product step, two divisions, then the update, then the events one by one.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) state <= S_MUL;
        end
        S_MUL: begin
          sel   <= 1'b0;
          state <= S_LOAD;
        end
        S_LOAD: begin
          cnt   <= '0;
          state <= S_STEP;
        end
        S_STEP: begin
          cnt <= cnt + 1'b1;
          if (cnt == CntW'(DivBits - 1)) state <= S_SAVE;
        end
        S_SAVE: begin
          if (sel) begin
            state <= S_UPD;
          end else begin
            sel   <= 1'b1;
            state <= S_LOAD;
          end
        end
        S_UPD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!stat.pend_any) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/geq_dp.sv
// Datapath of the gamepad event qualifier: configuration, state, divider,
// event list and output register. Depends on geq_pkg.
`default_nettype none
module geq_dp (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic [151:0]       s_tdata,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  output logic [31:0]             m_tdata,
  output logic [2:0]              m_tuser,
  output logic                    m_tlast,
  input  wire geq_pkg::geq_cmd_t  cmd,
  output geq_pkg::geq_stat_t      stat
);
  import geq_pkg::*;

  typedef struct packed {
    logic        fire;
    logic [1:0]  dir;
    logic [2:0]  held;
    logic [15:0] timer;
  } walk_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  code;
    logic        flag;
    logic [12:0] x;
    logic [12:0] y;
  } ev_t;

  // Configuration registers.
  logic [14:0] deadzone;
  logic [15:0] repeat_ms;
  logic [7:0]  max_speed;
  logic [14:0] trig_thr;
  logic [13:0] win_w;
  logic [13:0] win_h;

  // Captured sample.
  logic signed [15:0] lx, ly, rx, ry;
  logic [14:0] lt, rt;
  logic [10:0] btn;
  logic [12:0] hx, hy;
  logic [15:0] elapsed;

  // Persistent state.
  logic [3:0]  prev_dpad;
  logic [2:0]  walk_x_held, walk_y_held;
  logic [15:0] walk_x_timer, walk_y_timer;
  logic        cursor_active;
  logic [12:0] cursor_pos_x, cursor_pos_y;
  logic [7:0]  prev_buttons;

  // Arithmetic.
  logic [DivBits-1:0] prod_x, prod_y;
  logic               neg_x, neg_y;
  logic [DivBits-1:0] quot;
  logic [15:0]        rem;
  logic signed [10:0] speed_x, speed_y;

  // Event list.
  logic [NumSlots-1:0] pend;
  logic                lb_q;
  logic [1:0]          wx_dir, wy_dir;
  logic                cur_flag;
  logic [12:0]         cur_x, cur_y, clk_x, clk_y;
  logic [1:0]          mouse_val;

  // Output register.
  ev_t  out_ev;
  logic out_last;

  function automatic walk_t walk_f(input logic signed [15:0] v, input logic [1:0] nd,
                                   input logic [1:0] pd, input logic [2:0] held,
                                   input logic [15:0] timer, input logic [15:0] el,
                                   input logic [14:0] dz, input logic [15:0] iv);
    logic signed [16:0] sv, sdz;
    logic [16:0]        sum;
    logic [15:0]        t;
    logic [1:0]         dir;
    logic               hold;
    walk_t              r;
    sv   = {v[15], v};
    sdz  = {2'b00, dz};
    r    = '0;
    dir  = nd;
    hold = 1'b1;
    if (sv < -sdz) dir = nd;
    else if (sv > sdz) dir = pd;
    else hold = 1'b0;
    if (hold) begin
      r.dir = dir;
      if (!held[2] || held[1:0] != dir) begin
        r.fire = 1'b1;
        r.held = {1'b1, dir};
      end else begin
        r.held = held;
        sum = {1'b0, timer} + {1'b0, el};
        t   = sum[16] ? 16'hFFFF : sum[15:0];
        if (t >= iv) begin
          r.fire = 1'b1;
        end else begin
          r.timer = t;
        end
      end
    end
    return r;
  endfunction

  // Magnitude of a stick offset beyond the deadzone, with its sign.
  function automatic logic [16:0] offs_f(input logic signed [15:0] v,
                                         input logic [14:0] dz);
    logic signed [16:0] sv, sdz, num;
    logic [15:0]        mag;
    sv  = {v[15], v};
    sdz = {2'b00, dz};
    if (sv > sdz) num = sv - sdz;
    else if (sv < -sdz) num = sv + sdz;
    else num = '0;
    mag = num[16] ? 16'(-num) : num[15:0];
    return {num[16], mag};
  endfunction

  function automatic logic [12:0] clamp_f(input logic [12:0] pos,
                                          input logic signed [10:0] sp,
                                          input logic [13:0] size);
    logic signed [14:0] p;
    logic [13:0]        s;
    logic [12:0]        lim;
    s   = (size == 14'd0) ? 14'd1 : ((size > 14'd8192) ? 14'd8192 : size);
    lim = 13'(s - 14'd1);
    p   = $signed({2'b00, pos}) + 15'(sp);
    if (p < 0) return '0;
    if (p > $signed({2'b00, lim})) return lim;
    return p[12:0];
  endfunction

  logic [16:0] offs_x, offs_y;
  logic [14:0] den;
  logic [15:0] rem_sh;
  walk_t       wx, wy;
  logic        moving;
  logic [12:0] base_x, base_y, new_x, new_y, cx, cy;
  logic [7:0]  now_b;
  logic [NumSlots-1:0] pick;
  ev_t         nxt;

  assign offs_x = offs_f(rx, deadzone);
  assign offs_y = offs_f(ry, deadzone);
  assign den    = (deadzone == FULL_SCALE) ? 15'd1 : FULL_SCALE - deadzone;
  assign rem_sh = {rem[14:0], quot[DivBits-1]};

  // Per-sample decisions taken in the update step.
  always_comb begin
    wx = walk_f(lx, DIR_LEFT, DIR_RIGHT, walk_x_held, walk_x_timer, elapsed,
                deadzone, repeat_ms);
    wy = walk_f(ly, DIR_UP, DIR_DOWN, walk_y_held, walk_y_timer, elapsed,
                deadzone, repeat_ms);
    moving = (offs_x[15:0] != 16'd0) || (offs_y[15:0] != 16'd0);
    base_x = cursor_active ? cursor_pos_x : hx;
    base_y = cursor_active ? cursor_pos_y : hy;
    new_x  = clamp_f(base_x, speed_x, win_w);
    new_y  = clamp_f(base_y, speed_y, win_h);
    cx     = moving ? new_x : hx;
    cy     = moving ? new_y : hy;
    now_b  = {btn[10], rt > trig_thr, lt > trig_thr, btn[8:4]};
  end

  // Lowest pending slot and its event.
  always_comb begin
    pick = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (pend[i]) pick = NumSlots'(1) << i;
    end
    nxt = '0;
    if (pick[0])       begin nxt.kind = KIND_DPAD; nxt.code = {1'b0, DIR_LEFT};  nxt.flag = lb_q; end
    else if (pick[1])  begin nxt.kind = KIND_DPAD; nxt.code = {1'b0, DIR_RIGHT}; nxt.flag = lb_q; end
    else if (pick[2])  begin nxt.kind = KIND_DPAD; nxt.code = {1'b0, DIR_UP};    nxt.flag = lb_q; end
    else if (pick[3])  begin nxt.kind = KIND_DPAD; nxt.code = {1'b0, DIR_DOWN};  nxt.flag = lb_q; end
    else if (pick[4])  begin nxt.kind = KIND_WALK; nxt.code = {1'b0, wx_dir}; end
    else if (pick[5])  begin nxt.kind = KIND_WALK; nxt.code = {1'b0, wy_dir}; end
    else if (pick[6])  begin
      nxt.kind = KIND_CURSOR; nxt.flag = cur_flag; nxt.x = cur_x; nxt.y = cur_y;
    end
    else if (pick[7])  begin
      nxt.kind = KIND_MOUSE; nxt.code = 3'd1; nxt.flag = mouse_val[0];
      nxt.x = clk_x; nxt.y = clk_y;
    end
    else if (pick[8])  begin
      nxt.kind = KIND_MOUSE; nxt.code = 3'd2; nxt.flag = mouse_val[1];
      nxt.x = clk_x; nxt.y = clk_y;
    end
    else if (pick[9])  begin nxt.kind = KIND_ACTION; nxt.code = lb_q ? 3'd4 : 3'd1; end
    else if (pick[10]) begin nxt.kind = KIND_ACTION; nxt.code = lb_q ? 3'd5 : 3'd2; end
    else if (pick[11]) begin nxt.kind = KIND_ACTION; nxt.code = lb_q ? 3'd6 : 3'd3; end
    else if (pick[12]) nxt.kind = KIND_TARGET;
    else if (pick[13]) nxt.kind = KIND_CAPT;
    else if (pick[14]) nxt.kind = KIND_SELECT;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadzone  <= 15'd8000;
      repeat_ms <= 16'd200;
      max_speed <= 8'd10;
      trig_thr  <= 15'd16000;
      win_w     <= 14'd1024;
      win_h     <= 14'd768;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEADZONE: deadzone  <= cfg_data[14:0];
        REG_REPEAT:   repeat_ms <= cfg_data;
        REG_SPEED:    max_speed <= cfg_data[7:0];
        REG_TRIGGER:  trig_thr  <= cfg_data[14:0];
        REG_WIDTH:    win_w     <= cfg_data[13:0];
        REG_HEIGHT:   win_h     <= cfg_data[13:0];
        default: ;
      endcase
    end
  end

  // Sample capture, products and the shared restoring divider.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lx      <= s_tdata[15:0];
      ly      <= s_tdata[31:16];
      rx      <= s_tdata[47:32];
      ry      <= s_tdata[63:48];
      lt      <= s_tdata[78:64];
      rt      <= s_tdata[93:79];
      btn     <= s_tdata[104:94];
      hx      <= s_tdata[117:105];
      hy      <= s_tdata[130:118];
      elapsed <= s_tdata[146:131];
    end
    if (cmd.mul) begin
      prod_x <= DivBits'(offs_x[15:0]) * DivBits'(max_speed);
      prod_y <= DivBits'(offs_y[15:0]) * DivBits'(max_speed);
      neg_x  <= offs_x[16];
      neg_y  <= offs_y[16];
    end
    if (cmd.dload) begin
      quot <= cmd.dsel ? prod_y : prod_x;
      rem  <= '0;
    end else if (cmd.dstep) begin
      if (rem_sh >= {1'b0, den}) begin
        rem  <= rem_sh - {1'b0, den};
        quot <= {quot[DivBits-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        quot <= {quot[DivBits-2:0], 1'b0};
      end
    end
    if (cmd.dsave) begin
      if (cmd.dsel) speed_y <= neg_y ? -$signed({1'b0, quot[9:0]}) : $signed({1'b0, quot[9:0]});
      else          speed_x <= neg_x ? -$signed({1'b0, quot[9:0]}) : $signed({1'b0, quot[9:0]});
    end
  end

  // State update and event list.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_dpad     <= '0;
      walk_x_held   <= '0;
      walk_y_held   <= '0;
      walk_x_timer  <= '0;
      walk_y_timer  <= '0;
      cursor_active <= 1'b0;
      cursor_pos_x  <= '0;
      cursor_pos_y  <= '0;
      prev_buttons  <= '0;
      pend          <= '0;
    end else if (cmd.upd) begin
      pend[0]  <= btn[2] & ~prev_dpad[2];
      pend[1]  <= btn[3] & ~prev_dpad[3];
      pend[2]  <= btn[0] & ~prev_dpad[0];
      pend[3]  <= btn[1] & ~prev_dpad[1];
      pend[4]  <= wx.fire;
      pend[5]  <= wy.fire;
      pend[6]  <= moving | cursor_active;
      pend[7]  <= now_b[0] ^ prev_buttons[0];
      pend[8]  <= now_b[1] ^ prev_buttons[1];
      pend[14:9] <= now_b[7:2] & ~prev_buttons[7:2];
      prev_dpad    <= btn[3:0];
      walk_x_held  <= wx.held;
      walk_y_held  <= wy.held;
      walk_x_timer <= wx.timer;
      walk_y_timer <= wy.timer;
      cursor_active <= moving;
      if (moving) begin
        cursor_pos_x <= new_x;
        cursor_pos_y <= new_y;
      end
      prev_buttons <= now_b;
    end else if (cmd.emit) begin
      pend <= pend & ~pick;
    end
  end

  // Event fields that ride with the pending list.
  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      lb_q      <= btn[9];
      wx_dir    <= wx.dir;
      wy_dir    <= wy.dir;
      cur_flag  <= moving;
      cur_x     <= moving ? new_x : 13'd0;
      cur_y     <= moving ? new_y : 13'd0;
      clk_x     <= cx;
      clk_y     <= cy;
      mouse_val <= now_b[1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_ev   <= nxt;
      out_last <= (pend & ~pick) == '0;
    end
  end

  assign m_tdata = {2'b00, out_ev.y, out_ev.x, out_ev.flag, out_ev.code};
  assign m_tuser = out_ev.kind;
  assign m_tlast = out_last;

  assign stat.pend_any = |pend;
  assign stat.out_free = !m_tvalid || m_tready;

endmodule
`default_nettype wire
